// ===== rtl/todc_pkg.sv =====
// Shared types and constants for the time-of-day clock with alarm compare.
`timescale 1ns / 1ps

package todc_pkg;

  localparam int SEC_W      = 6;
  localparam int MIN_W      = 6;
  localparam int HOUR_W     = 5;
  localparam int MS_OUT_W   = 10;
  localparam int TOD_W      = 27;
  localparam int ALARM_CNT  = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 27;

  localparam int SECONDS_PER_MINUTE = 60;
  localparam int MINUTES_PER_HOUR   = 60;
  localparam int HOURS_PER_DAY      = 24;
  localparam int MS_PER_SECOND      = 1000;
  localparam int MS_PER_MINUTE      = MS_PER_SECOND * SECONDS_PER_MINUTE;
  localparam int MS_PER_HOUR        = MS_PER_MINUTE * MINUTES_PER_HOUR;

  // item kinds on in_tuser
  localparam logic FUNC_TICK     = 1'b0;
  localparam logic FUNC_SET_TIME = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ONE_TIME   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ONE_MS     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TWO_TIME   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TWO_MS     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_THREE_TIME = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_THREE_MS   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_FOUR_TIME  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_FOUR_MS    = 4'd7;

  typedef struct packed {
    logic [SEC_W-1:0]  set_seconds;
    logic [MIN_W-1:0]  set_minutes;
    logic [HOUR_W-1:0] set_hours;
    logic              hold;
    logic              func;
  } todc_in_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } todc_time_t;

endpackage

// ===== rtl/todc_step.sv =====
// Input register and the millisecond/second/minute/hour counter cascade.
`timescale 1ns / 1ps

module todc_step #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  todc_pkg::todc_in_t                      in_item,
  output logic                                    step_valid,
  input  logic                                    step_ready,
  output todc_pkg::todc_time_t                    step_time,
  output logic [$clog2(TICKS_PER_SECOND)-1:0]     step_ms,
  output logic                                    step_wrapped
);
  import todc_pkg::*;

  localparam int MS_W = $clog2(TICKS_PER_SECOND);

  logic                 in_valid_r, in_valid_nxt;
  todc_in_t             in_item_r;
  logic                 step_valid_r, step_valid_nxt;
  logic [MS_W-1:0]      ms_r, ms_nxt;
  logic [SEC_W-1:0]     sec_r, sec_nxt;
  logic [MIN_W-1:0]     min_r, min_nxt;
  logic [HOUR_W-1:0]    hour_r, hour_nxt;
  logic                 wrap_r, wrap_nxt;

  logic                 adv_step;
  logic [MS_W:0]        ms_inc;
  logic                 sec_carry;
  logic [SEC_W:0]       sec_sum;
  logic [MIN_W:0]       min_sum;
  logic [HOUR_W:0]      hour_sum;
  logic                 sec_wrap, min_wrap, hour_wrap;

  // the state registers double as the payload of the step stage
  assign adv_step = in_valid_r && (!step_valid_r || step_ready);
  assign in_ready = !in_valid_r || adv_step;

  always_comb begin
    ms_inc    = {1'b0, ms_r} + (MS_W + 1)'(1);
    sec_carry = (ms_inc >= (MS_W + 1)'(TICKS_PER_SECOND));
    sec_sum   = {1'b0, sec_r} + (SEC_W + 1)'(sec_carry);
    sec_wrap  = (sec_sum >= (SEC_W + 1)'(SECONDS_PER_MINUTE));
    min_sum   = {1'b0, min_r} + (MIN_W + 1)'(sec_wrap);
    min_wrap  = (min_sum >= (MIN_W + 1)'(MINUTES_PER_HOUR));
    hour_sum  = {1'b0, hour_r} + (HOUR_W + 1)'(min_wrap);
    hour_wrap = (hour_sum >= (HOUR_W + 1)'(HOURS_PER_DAY));

    ms_nxt   = ms_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    wrap_nxt = wrap_r;
    if (adv_step) begin
      wrap_nxt = 1'b0;
      if (in_item_r.func == FUNC_SET_TIME) begin
        ms_nxt   = '0;
        sec_nxt  = in_item_r.set_seconds;
        min_nxt  = in_item_r.set_minutes;
        hour_nxt = in_item_r.set_hours;
      end else begin
        ms_nxt = sec_carry ? '0 : ms_inc[MS_W-1:0];
        // hold freezes the cascade, milliseconds still roll over
        if (!in_item_r.hold) begin
          sec_nxt  = sec_wrap  ? '0 : sec_sum[SEC_W-1:0];
          min_nxt  = min_wrap  ? '0 : min_sum[MIN_W-1:0];
          hour_nxt = hour_wrap ? '0 : hour_sum[HOUR_W-1:0];
          wrap_nxt = hour_wrap;
        end
      end
    end

    if (adv_step) begin
      step_valid_nxt = 1'b1;
    end else if (step_ready) begin
      step_valid_nxt = 1'b0;
    end else begin
      step_valid_nxt = step_valid_r;
    end

    if (in_ready) begin
      in_valid_nxt = in_valid;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      step_valid_r <= 1'b0;
      ms_r         <= '0;
      sec_r        <= '0;
      min_r        <= '0;
      hour_r       <= '0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      step_valid_r <= step_valid_nxt;
      ms_r         <= ms_nxt;
      sec_r        <= sec_nxt;
      min_r        <= min_nxt;
      hour_r       <= hour_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
    wrap_r <= wrap_nxt;
  end

  assign step_valid         = step_valid_r;
  assign step_time.hours    = hour_r;
  assign step_time.minutes  = min_r;
  assign step_time.seconds  = sec_r;
  assign step_ms            = ms_r;
  assign step_wrapped       = wrap_r;

  a_ms_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (MS_W + 1)'(ms_r) < (MS_W + 1)'(TICKS_PER_SECOND))
    else $error("millisecond count reached the tick limit");

  a_wrap_means_midnight: assert property (@(posedge clk) disable iff (!rst_n)
    step_valid_r && wrap_r |-> hour_r == '0)
    else $error("day wrap flagged with nonzero hours");

  a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    adv_step && in_item_r.func == FUNC_TICK && in_item_r.hold
    |=> hour_r == $past(hour_r) && min_r == $past(min_r) && sec_r == $past(sec_r) && !wrap_r)
    else $error("held tick moved the time of day");

endmodule

// ===== rtl/todc_alarm.sv =====
// Alarm registers, time-of-day compare and the result register.
`timescale 1ns / 1ps

module todc_alarm #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr,
  input  logic [todc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [todc_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    step_valid,
  output logic                                    step_ready,
  input  todc_pkg::todc_time_t                    step_time,
  input  logic [$clog2(TICKS_PER_SECOND)-1:0]     step_ms,
  input  logic                                    step_wrapped,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [todc_pkg::ALARM_CNT-1:0]          out_hits,
  output logic                                    out_wrapped,
  output logic [todc_pkg::MS_OUT_W-1:0]           out_ms,
  output todc_pkg::todc_time_t                    out_time
);
  import todc_pkg::*;

  localparam int MS_W  = $clog2(TICKS_PER_SECOND);
  localparam int CMP_W = (MS_W > MS_OUT_W) ? MS_W : MS_OUT_W;

  logic [TOD_W-1:0]    alarm_time_r [ALARM_CNT];
  logic [MS_OUT_W-1:0] alarm_ms_r   [ALARM_CNT];

  logic                out_valid_r, out_valid_nxt;
  logic [ALARM_CNT-1:0] hits_r, hits_nxt;
  logic                wrapped_r;
  logic [MS_OUT_W-1:0] ms_r;
  todc_time_t          time_r;

  logic [TOD_W-1:0]    tod;
  logic [CMP_W-1:0]    ms_ext;
  logic                load;

  assign step_ready = !out_valid_r || out_ready;
  assign load       = step_valid && step_ready;

  // whole-second time of day in ms; fits 27 bits even for out-of-range counts
  always_comb begin
    tod = TOD_W'(step_time.hours) * TOD_W'(MS_PER_HOUR)
        + TOD_W'(step_time.minutes) * TOD_W'(MS_PER_MINUTE)
        + TOD_W'(step_time.seconds) * TOD_W'(MS_PER_SECOND);
    ms_ext = CMP_W'(step_ms);
    for (int i = 0; i < ALARM_CNT; i++) begin
      hits_nxt[i] = (tod == alarm_time_r[i]) && (ms_ext == CMP_W'(alarm_ms_r[i]));
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALARM_CNT; i++) begin
        alarm_time_r[i] <= '0;
        alarm_ms_r[i]   <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_ALARM_ONE_TIME:   alarm_time_r[0] <= cfg_data[TOD_W-1:0];
        REG_ALARM_ONE_MS:     alarm_ms_r[0]   <= cfg_data[MS_OUT_W-1:0];
        REG_ALARM_TWO_TIME:   alarm_time_r[1] <= cfg_data[TOD_W-1:0];
        REG_ALARM_TWO_MS:     alarm_ms_r[1]   <= cfg_data[MS_OUT_W-1:0];
        REG_ALARM_THREE_TIME: alarm_time_r[2] <= cfg_data[TOD_W-1:0];
        REG_ALARM_THREE_MS:   alarm_ms_r[2]   <= cfg_data[MS_OUT_W-1:0];
        REG_ALARM_FOUR_TIME:  alarm_time_r[3] <= cfg_data[TOD_W-1:0];
        REG_ALARM_FOUR_MS:    alarm_ms_r[3]   <= cfg_data[MS_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hits_r    <= hits_nxt;
      wrapped_r <= step_wrapped;
      ms_r      <= ms_ext[MS_OUT_W-1:0];
      time_r    <= step_time;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hits    = hits_r;
  assign out_wrapped = wrapped_r;
  assign out_ms      = ms_r;
  assign out_time    = time_r;

  // a hit must agree with the alarm's ms register on the shown bits
  for (genvar g = 0; g < ALARM_CNT; g++) begin : g_hit_chk
    a_hit_ms: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && hits_r[g] |-> ms_r == alarm_ms_r[g])
      else $error("alarm hit without matching millisecond");
  end

endmodule

// ===== rtl/time_of_day_clock_with_alarms.sv =====
// Top level: time-of-day clock with four alarm compares on stream ports.
//
//  channel | ports                    | payload
//  --------+--------------------------+----------------------------------------------
//  in      | in_tvalid/in_tready      | tuser func; tdata hold, hours, minutes, seconds
//  out     | out_tvalid/out_tready    | tdata hits, day_wrapped, ms, sec, min, hours
//  cfg     | cfg_valid/cfg_ready      | cfg_index 0..7 alarm regs, higher ignored
//
// One item per cycle sustained while out_tready stays high; an accepted item passes
// the input register, then the counter step registers, then the alarm compare /
// result register before out_tvalid rises.
// The counter cascade updates the time state as an item leaves the input register.
// Reset is synchronous: counts and alarm registers clear to zero, nothing is pending.
// out_tready low stalls each stage only when the stage ahead of it is full.
// cfg_ready is always high; write alarms only while no item is in flight.
`timescale 1ns / 1ps

module time_of_day_clock_with_alarms #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [23:0]                         in_tdata,   // hold, set_hours, set_minutes, set_seconds
  input  logic                                in_tuser,   // func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // alarm_hits, day_wrapped, now_ms,
                                                          // now_seconds, now_minutes, now_hours
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [todc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [todc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import todc_pkg::*;

  localparam int MS_W = $clog2(TICKS_PER_SECOND);

  todc_in_t             in_item;
  logic                 step_valid, step_ready, step_wrapped;
  todc_time_t           step_time;
  logic [MS_W-1:0]      step_ms;
  logic [ALARM_CNT-1:0] out_hits;
  logic                 out_wrapped;
  logic [MS_OUT_W-1:0]  out_ms;
  todc_time_t           out_time;

  assign in_item.func        = in_tuser;
  assign in_item.hold        = in_tdata[0];
  assign in_item.set_hours   = in_tdata[5:1];
  assign in_item.set_minutes = in_tdata[11:6];
  assign in_item.set_seconds = in_tdata[17:12];

  assign cfg_ready = 1'b1;

  todc_step #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_item      (in_item),
    .step_valid   (step_valid),
    .step_ready   (step_ready),
    .step_time    (step_time),
    .step_ms      (step_ms),
    .step_wrapped (step_wrapped)
  );

  todc_alarm #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_alarm (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step_valid   (step_valid),
    .step_ready   (step_ready),
    .step_time    (step_time),
    .step_ms      (step_ms),
    .step_wrapped (step_wrapped),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_hits     (out_hits),
    .out_wrapped  (out_wrapped),
    .out_ms       (out_ms),
    .out_time     (out_time)
  );

  assign out_tdata = {out_time.hours, out_time.minutes, out_time.seconds,
                      out_ms, out_wrapped, out_hits};

endmodule
